[hdl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands; clk and rst_n come from the user.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/smbpec_pkg.sv]
// ============================================================================
// smbpec_pkg
// Types, constants and the CRC-8 step shared by the PEC checker modules.
// ============================================================================
package smbpec_pkg;

    localparam int MAX_DATA_BYTES = 32;
    localparam int STORE_DEPTH    = 32;
    localparam int LEN_CAP        = (MAX_DATA_BYTES < STORE_DEPTH) ? MAX_DATA_BYTES
                                                                   : STORE_DEPTH;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int LEN_W          = 6;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CRC_POLY = 8'h07;   // x^8 + x^2 + x + 1

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DATA_OK  = 2'd0,
        ST_BAD_PEC  = 2'd1,
        ST_BAD_ECHO = 2'd2,
        ST_EMPTY_OK = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } back_state_t;

    // frame verdict handed from front to back
    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length;
    } verdict_t;

    // payload store write port
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
    } mem_wr_t;

    // one byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[hdl/smbpec_front.sv]
// ============================================================================
// smbpec_front
// Frame tracking, CRC accumulation, payload writes and frame verdicts.
// ============================================================================
`include "assert_macros.svh"

module smbpec_front
    import smbpec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              action,
    input  logic [7:0]        reg_number,
    input  logic [LEN_W-1:0]  data_length,
    input  logic [7:0]        frame_byte,
    input  logic              cfg_write,
    input  logic [6:0]        cfg_data,
    input  logic              q_full,
    input  logic              stream_pending,
    output logic              q_push,
    output verdict_t          q_data,
    output mem_wr_t           mem_wr
);

    logic [6:0]        dev_addr_reg;
    logic [7:0]        crc_reg, crc_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [7:0]        exp_reg_reg, exp_reg_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic              echo_ok_reg, echo_ok_next;
    logic              active_reg, active_next;

    logic              accept;
    logic              in_body;
    logic              in_data;
    logic [LEN_W:0]    body_end;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  data_off;
    logic              take_byte;

    assign body_end = {1'b0, exp_len_reg} + (LEN_W+1)'(2);
    assign in_body  = {1'b0, pos_reg} < body_end;
    assign in_data  = (pos_reg >= LEN_W'(2)) && in_body;
    assign data_off = pos_reg - LEN_W'(2);
    assign len_sat  = (data_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : data_length;

    // hold data bytes back while the store still feeds an earlier frame
    assign full      = q_full || (active_reg && in_data && stream_pending);
    assign accept    = push && !full;
    assign take_byte = accept && (action == ACT_BYTE) && active_reg;

    always_comb
    begin
        crc_next     = crc_reg;
        pos_next     = pos_reg;
        exp_reg_next = exp_reg_reg;
        exp_len_next = exp_len_reg;
        echo_ok_next = echo_ok_reg;
        active_next  = active_reg;
        q_push       = 1'b0;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = data_off[ADDR_W-1:0];
        mem_wr.data  = frame_byte;

        if (frame_byte != crc_reg)
            q_data.status = ST_BAD_PEC;
        else if (!echo_ok_reg)
            q_data.status = ST_BAD_ECHO;
        else if (exp_len_reg == '0)
            q_data.status = ST_EMPTY_OK;
        else
            q_data.status = ST_DATA_OK;
        q_data.length = exp_len_reg;

        if (accept && (action == ACT_START))
        begin
            exp_reg_next = reg_number;
            exp_len_next = len_sat;
            pos_next     = '0;
            echo_ok_next = 1'b0;
            crc_next     = crc8_byte({dev_addr_reg, 1'b1});
            active_next  = 1'b1;
        end
        else if (take_byte)
        begin
            if (in_body)
            begin
                if (pos_reg == LEN_W'(1))
                    echo_ok_next = (frame_byte == exp_reg_reg);
                mem_wr.en = in_data;
                crc_next  = crc8_byte(crc_reg ^ frame_byte);
                pos_next  = pos_reg + LEN_W'(1);
            end
            else
            begin
                // PEC byte closes the frame
                q_push      = 1'b1;
                active_next = 1'b0;
                pos_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= '0;
            crc_reg      <= '0;
            pos_reg      <= '0;
            exp_reg_reg  <= '0;
            exp_len_reg  <= '0;
            echo_ok_reg  <= 1'b0;
            active_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                dev_addr_reg <= cfg_data;
            crc_reg     <= crc_next;
            pos_reg     <= pos_next;
            exp_reg_reg <= exp_reg_next;
            exp_len_reg <= exp_len_next;
            echo_ok_reg <= echo_ok_next;
            active_reg  <= active_next;
        end
    end

    `ASSERT_IMPL(a_no_write_during_stream, mem_wr.en, !stream_pending)
    `ASSERT_IMPL(a_pos_within_frame, active_reg, {1'b0, pos_reg} <= body_end)

endmodule

[hdl/smbpec_queue.sv]
// ============================================================================
// smbpec_queue
// Short verdict queue between the front and the back.
// ============================================================================
`include "assert_macros.svh"

module smbpec_queue
    import smbpec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  verdict_t  push_data,
    output logic      full,
    input  logic      pop,
    output verdict_t  pop_data,
    output logic      empty,
    output logic      has_stream
);

    verdict_t              ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]    cnt_reg;
    logic                  do_push, do_pop;
    logic [Q_PTR_W-1:0]    offs;

    assign full     = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = ent_reg[rd_ptr_reg];

    // any queued verdict that will read the payload store
    always_comb
    begin
        has_stream = 1'b0;
        offs       = '0;
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            offs = Q_PTR_W'(i) - rd_ptr_reg;
            if (({1'b0, offs} < cnt_reg) && (ent_reg[i].status == ST_DATA_OK))
                has_stream = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
        end
    end

    `ASSERT_IMPL(a_no_overflow, push, !full)

endmodule

[hdl/smbpec_back.sv]
// ============================================================================
// smbpec_back
// Payload store and result sequencer with an output register.
// ============================================================================
`include "assert_macros.svh"

module smbpec_back
    import smbpec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  verdict_t          q_data,
    output logic              q_pop,
    input  mem_wr_t           mem_wr,
    output logic              busy,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic [7:0]        data_byte,
    output logic [4:0]        byte_index,
    output logic              is_last
);

    logic [7:0]         store_mem [STORE_DEPTH];
    logic [7:0]         rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic               res_valid_reg, res_valid_next;
    status_t            res_status_reg, res_status_next;
    logic [7:0]         res_data_reg, res_data_next;
    logic [ADDR_W-1:0]  res_index_reg, res_index_next;
    logic               res_last_reg, res_last_next;

    logic               load_ok;
    logic               res_load;
    logic               is_final;

    assign load_ok  = !res_valid_reg || pop;
    assign is_final = ({1'b0, idx_reg} + LEN_W'(1)) == len_reg;
    assign busy     = state_reg != BK_IDLE;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            store_mem[mem_wr.addr] <= mem_wr.data;
        rd_data_reg <= store_mem[idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && (q_data.status == ST_DATA_OK))
                    state_next = BK_READ;
            end
            BK_READ:
                state_next = BK_LOAD;
            BK_LOAD:
            begin
                if (load_ok)
                    state_next = is_final ? BK_IDLE : BK_READ;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop           = 1'b0;
        res_load        = 1'b0;
        idx_next        = idx_reg;
        len_next        = len_reg;
        res_status_next = q_data.status;
        res_data_next   = '0;
        res_index_next  = '0;
        res_last_next   = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.status == ST_DATA_OK)
                    begin
                        q_pop    = 1'b1;
                        idx_next = '0;
                        len_next = q_data.length;
                    end
                    else if (load_ok)
                    begin
                        q_pop    = 1'b1;
                        res_load = 1'b1;
                    end
                end
            end
            BK_READ:
            begin
            end
            BK_LOAD:
            begin
                res_status_next = ST_DATA_OK;
                res_data_next   = rd_data_reg;
                res_index_next  = idx_reg;
                res_last_next   = is_final;
                if (load_ok)
                begin
                    res_load = 1'b1;
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid_next = res_load ? 1'b1 : (pop ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_index_reg  <= res_index_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign empty      = !res_valid_reg;
    assign status     = res_status_reg;
    assign data_byte  = res_data_reg;
    assign byte_index = res_index_reg;
    assign is_last    = res_last_reg;

    `ASSERT_IMPL(a_index_in_range, state_reg == BK_LOAD, {1'b0, idx_reg} < len_reg)
    `ASSERT_NEXT(a_last_ends_stream, (state_reg == BK_LOAD) && load_ok && is_final,
                 (state_reg == BK_IDLE) && res_valid_reg && res_last_reg)

endmodule

[hdl/smbpec_block_read_pec_checker_core.sv]
// Order: with the result register free, a status-only item passes from the verdict queue into the
// result register after the PEC byte is taken; each data byte passes BK_READ, then BK_LOAD.
// Throughput: one input item per cycle; every item waits while the verdict queue is full,
// and data-phase bytes wait while the store is still streaming out an earlier frame.
// Reset (rst_n, asynchronous, active low): idle, no frame armed, queues empty,
// device address 0; the payload store is not cleared.
// ============================================================================
// smbus_block_read_pec_checker_core
// SMBus block-read response checker with PEC (CRC-8, x^8+x^2+x+1).
// ============================================================================
module smbus_block_read_pec_checker_core
    import smbpec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // input item queue
    input  logic         push,
    output logic         full,
    input  logic         action,
    input  logic [7:0]   reg_number,
    input  logic [5:0]   data_length,
    input  logic [7:0]   frame_byte,
    // result item queue
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   status,
    output logic [7:0]   data_byte,
    output logic [4:0]   byte_index,
    output logic         is_last,
    // device address register
    input  logic         cfg_write,
    input  logic [6:0]   cfg_data
);

    // Front end: takes every item, follows the frame position, runs the CRC
    // seeded with the read address byte, writes data bytes into the store and
    // issues one verdict per frame when the PEC byte arrives.
    // Back end: turns each verdict into either one status item or a stream of
    // data items read from the store. The verdict queue decouples the two.

    logic      q_push;
    verdict_t  q_push_data;
    logic      q_full;
    logic      q_pop;
    verdict_t  q_pop_data;
    logic      q_empty;
    logic      q_has_stream;
    logic      back_busy;
    logic      stream_pending;
    mem_wr_t   mem_wr;

    // store is owned by a data verdict from the moment it is queued until the
    // back end has read its last byte
    assign stream_pending = back_busy || q_has_stream;

    smbpec_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .reg_number     (reg_number),
        .data_length    (data_length),
        .frame_byte     (frame_byte),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .stream_pending (stream_pending),
        .q_push         (q_push),
        .q_data         (q_push_data),
        .mem_wr         (mem_wr)
    );

    smbpec_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_data   (q_pop_data),
        .empty      (q_empty),
        .has_stream (q_has_stream)
    );

    smbpec_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .mem_wr     (mem_wr),
        .busy       (back_busy),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .is_last    (is_last)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the SMBus block-read PEC checker. It drives start
// and response-byte items through the push/full side and keeps a cycle-free
// mirror of the frame state (CRC-8 seeded with the read address, register
// echo, payload buffer). Each popped result is compared with the oldest
// predicted one. Directed frames come first, then the length cap, address
// settings, a long output stall and random frame traffic.
// ============================================================================
module tb_top;
    import smbpec_pkg::*;

    localparam int STALL_LIMIT    = 3000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES  = 24;    // covers the longest store-read latency
    localparam int RX_HOLD_CYCLES = 400;
    localparam int REPORT_MAX     = 10;

    typedef enum int {
        FR_CLEAN,
        FR_BAD_PEC,
        FR_BAD_ECHO,
        FR_BAD_BOTH,
        FR_CUT
    } frame_fault_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic [4:0]  index;
        logic        last;
    } verdict_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        action;
    logic [7:0]  reg_number;
    logic [5:0]  data_length;
    logic [7:0]  frame_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [4:0]  byte_index;
    logic        is_last;
    logic        cfg_write;
    logic [6:0]  cfg_data;

    // mirror of the checker's frame state
    logic [6:0]  dev_addr_m;
    logic [7:0]  crc_m;
    int          pos_m;
    int          len_m;
    logic [7:0]  reg_m;
    logic        echo_ok_m;
    logic        armed_m;
    logic [7:0]  payload_m [STORE_DEPTH];

    verdict_item_t frame_verdicts[$];

    int items_sent;
    int mismatch_count;
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_request = 0;

    always #6 clk = ~clk;

    smbus_block_read_pec_checker_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .reg_number  (reg_number),
        .data_length (data_length),
        .frame_byte  (frame_byte),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .is_last     (is_last),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // CRC-8, x^8+x^2+x+1, MSB first
    // ------------------------------------------------------------------------
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8)
        begin
            r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advance the mirror by one accepted item; queue the results it causes.
    function automatic void apply_frame_item(input logic act, input logic [7:0] reg_no,
                                             input logic [5:0] len, input logic [7:0] b);
        verdict_item_t v;
        if (act == ACT_START)
        begin
            // a start always re-arms, dropping any frame in progress
            len_m     = (int'(len) > LEN_CAP) ? LEN_CAP : int'(len);
            reg_m     = reg_no;
            pos_m     = 0;
            echo_ok_m = 1'b0;
            crc_m     = crc8_next(8'h00, {dev_addr_m, 1'b1});
            armed_m   = 1'b1;
        end
        else if (armed_m)
        begin
            if (pos_m < len_m + 2)
            begin
                if (pos_m == 1)
                    echo_ok_m = (b == reg_m);
                else if (pos_m >= 2)
                    payload_m[pos_m - 2] = b;
                crc_m = crc8_next(crc_m, b);
                pos_m++;
            end
            else
            begin
                // PEC byte: checksum wins over a bad echo
                armed_m  = 1'b0;
                pos_m    = 0;
                v.status = ST_EMPTY_OK;
                v.data   = 8'h00;
                v.index  = 5'd0;
                v.last   = 1'b1;
                if (b != crc_m)
                    v.status = ST_BAD_PEC;
                else if (!echo_ok_m)
                    v.status = ST_BAD_ECHO;
                if (v.status != ST_EMPTY_OK || len_m == 0)
                    frame_verdicts.push_back(v);
                else
                begin
                    for (int i = 0; i < len_m; i++)
                    begin
                        v.status = ST_DATA_OK;
                        v.data   = payload_m[i];
                        v.index  = 5'(i);
                        v.last   = (i == len_m - 1);
                        frame_verdicts.push_back(v);
                    end
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [7:0] reg_no,
                             input logic [5:0] len, input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push        <= 1'b1;
        action      <= act;
        reg_number  <= reg_no;
        data_length <= len;
        frame_byte  <= b;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        apply_frame_item(act, reg_no, len, b);
    endtask

    // Start item, lead byte, echo, payload and PEC. fill < 0 means random payload.
    task automatic send_frame(input logic [7:0] reg_no, input logic [5:0] len,
                              input frame_fault_t fault, input int fill = -1);
        int         n;
        int         cut_at;
        logic [7:0] crc;
        logic [7:0] b;
        n      = (int'(len) > LEN_CAP) ? LEN_CAP : int'(len);
        cut_at = (fault == FR_CUT) ? $urandom_range(0, n + 2) : n + 3;
        send_item(ACT_START, reg_no, len, 8'($urandom));
        crc = crc8_next(8'h00, {dev_addr_m, 1'b1});
        for (int k = 0; k < cut_at; k++)
        begin
            if (k == 1)
            begin
                b = reg_no;
                if (fault == FR_BAD_ECHO || fault == FR_BAD_BOTH)
                    b = b ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (k == n + 2)
            begin
                b = crc;
                if (fault == FR_BAD_PEC || fault == FR_BAD_BOTH)
                    b = b ^ 8'($urandom_range(1, 255));
            end
            else if (k >= 2 && fill >= 0)
                b = 8'(fill);
            else
                b = 8'($urandom);
            crc = crc8_next(crc, b);
            // unused fields carry noise
            send_item(ACT_BYTE, 8'($urandom), 6'($urandom), b);
        end
    endtask

    // Drop push, wait for every predicted result, then let the pipe settle.
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (frame_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_device_address(input logic [6:0] addr);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= addr;
        @(negedge clk);
        cfg_write <= 1'b0;
        dev_addr_m = addr;
    endtask

    function automatic logic [5:0] pick_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 6'($urandom_range(0, 6));
        else if (pick < 18)
            return 6'($urandom_range(7, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Runs on the reset address: stray byte, empty payload, one 0xFF byte,
    // each error status, both errors at once, restart mid-frame.
    task automatic test_directed_frames();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(ACT_BYTE, 8'h00, 6'h00, 8'hFF);
        send_frame(8'hFF, 6'd0, FR_CLEAN);
        send_frame(8'h00, 6'd1, FR_CLEAN, 8'hFF);
        send_frame(8'hA5, 6'd0, FR_BAD_PEC);
        send_frame(8'h3C, 6'd0, FR_BAD_ECHO);
        send_frame(8'hC3, 6'd0, FR_BAD_BOTH);
        send_item(ACT_START, 8'h11, 6'd4, 8'h00);
        send_item(ACT_BYTE, 8'h00, 6'h00, 8'h22);
        send_frame(8'h11, 6'd0, FR_CLEAN);
        drain_results();
    endtask

    // Lengths above the store depth saturate.
    task automatic test_length_cap();
        tx_idle_on = 1'b1;
        send_frame(8'($urandom), 6'h3F, FR_CLEAN);
        tx_idle_on = 1'b0;
        send_frame(8'($urandom), 6'd33, FR_BAD_PEC, 8'h00);
        send_frame(8'($urandom), 6'd32, FR_CLEAN, 8'h00);
        drain_results();
    endtask

    task automatic test_address_sweep();
        logic [6:0] addr_list [3];
        addr_list[0] = 7'h7F;
        addr_list[1] = 7'h00;
        addr_list[2] = 7'($urandom);
        tx_idle_on = 1'b1;
        foreach (addr_list[a])
        begin
            set_device_address(addr_list[a]);
            repeat (2)
                send_frame(8'($urandom), 6'($urandom_range(0, 5)), FR_CLEAN);
            drain_results();
        end
    endtask

    // Receiver sits still while the sender keeps offering; the second frame's
    // payload bytes must back up against full.
    task automatic test_output_stall();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b1;
        hold_request = RX_HOLD_CYCLES;
        send_frame(8'($urandom), 6'd12, FR_CLEAN);
        send_frame(8'($urandom), 6'd12, FR_CLEAN);
        send_frame(8'($urandom), 6'd3, FR_CLEAN);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int pick;
        int phase_end;
        for (int phase = 0; phase < 2; phase++)
        begin
            set_device_address(7'($urandom));
            phase_end = items_sent + 20;
            while (items_sent < phase_end)
            begin
                // mostly idling, with some back-to-back stretches
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_item(ACT_BYTE, 8'($urandom), 6'($urandom), 8'($urandom));
                else if (pick < 3)
                    send_frame(8'($urandom), pick_length(), FR_CUT);
                else if (pick < 5)
                    send_frame(8'($urandom), pick_length(), FR_BAD_PEC);
                else if (pick < 7)
                    send_frame(8'($urandom), pick_length(), FR_BAD_ECHO);
                else if (pick == 7)
                    send_frame(8'($urandom), pick_length(), FR_BAD_BOTH);
                else
                    send_frame(8'($urandom), pick_length(), FR_CLEAN);
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: pop with random gaps, long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : result_drain
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                pop <= 1'b0;
                gap_left--;
            end
            else
                pop <= 1'b1;
            @(posedge clk);
            if (pop && !empty)
                gap_left = rx_idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    // compare each popped item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        verdict_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (frame_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result with none pending: status=%0d data=%h idx=%0d last=%b",
                             $realtime, status, data_byte, byte_index, is_last);
            end
            else
            begin
                want = frame_verdicts.pop_front();
                if (status !== want.status || data_byte !== want.data ||
                    byte_index !== want.index || is_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: mismatch exp status=%0d data=%h idx=%0d last=%b, %s%0d %h %0d %b",
                                 $realtime, want.status, want.data, want.index, want.last,
                                 "got ", status, data_byte, byte_index, is_last);
                end
            end
        end
    end

    // ends the run if nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        push           = 1'b0;
        action         = ACT_START;
        reg_number     = 8'h00;
        data_length    = 6'h00;
        frame_byte     = 8'h00;
        cfg_write      = 1'b0;
        cfg_data       = 7'h00;
        dev_addr_m     = 7'h00;
        crc_m          = 8'h00;
        pos_m          = 0;
        len_m          = 0;
        reg_m          = 8'h00;
        echo_ok_m      = 1'b0;
        armed_m        = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_length_cap();
        test_address_sweep();
        test_output_stall();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
